### src/bsm_pkg.sv
// package for the byte stack machine core: sizes, opcodes, sequencer states
`default_nettype none
package bsm_pkg;
    localparam int MemBytes = 65536;
    localparam int MemAw    = $clog2(MemBytes);

    // item operations
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_BOOT = 2'd2;
    localparam logic [1:0] OP_EXEC = 2'd3;

    // instruction opcodes
    localparam logic [7:0] I_BRK  = 8'h00;
    localparam logic [7:0] I_PUSH = 8'h20;
    localparam logic [7:0] I_DROP = 8'h30;
    localparam logic [7:0] I_SWAP = 8'h40;
    localparam logic [7:0] I_PICK = 8'h41;
    localparam logic [7:0] I_PAST = 8'h42;
    localparam logic [7:0] I_ROLL = 8'h50;
    localparam logic [7:0] I_INS  = 8'h51;
    localparam logic [7:0] I_LD   = 8'h60;
    localparam logic [7:0] I_ST   = 8'h61;
    localparam logic [7:0] I_JMP  = 8'h70;
    localparam logic [7:0] I_BR   = 8'h71;
    localparam logic [7:0] I_CALL = 8'h72;
    localparam logic [7:0] I_SEI  = 8'h80;
    localparam logic [7:0] I_SIV  = 8'h81;
    localparam logic [7:0] I_ADD  = 8'h90;
    localparam logic [7:0] I_SUB  = 8'h91;
    localparam logic [7:0] I_ADC  = 8'ha0;
    localparam logic [7:0] I_SBB  = 8'ha1;
    localparam logic [7:0] I_AND  = 8'hb0;
    localparam logic [7:0] I_OR   = 8'hb1;
    localparam logic [7:0] I_XOR  = 8'hb2;
    localparam logic [7:0] I_SHL  = 8'hc0;
    localparam logic [7:0] I_SHR  = 8'hc1;
    localparam logic [7:0] I_EQ   = 8'hd0;
    localparam logic [7:0] I_NE   = 8'hd1;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;  // issue read of r_addr
    localparam logic [3:0] S_WT   = 4'd2;  // read data arrives
    localparam logic [3:0] S_WR   = 4'd3;  // write r_wdata at r_addr
    localparam logic [3:0] S_OUT  = 4'd4;

    // mask a pointer to the active address width
    function automatic logic [63:0] wmask(input logic [1:0] sz, input logic [63:0] v);
        logic [63:0] r;
        case (sz)
            2'd0:    r = {56'd0, v[7:0]};
            2'd1:    r = {48'd0, v[15:0]};
            2'd2:    r = {32'd0, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

### src/bsm_ram.sv
// generic single port ram with registered read
`default_nettype none
module bsm_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_addr,
    input  wire [Width-1:0]         i_wdata,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write, and registered read (old data on a write)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### src/byte_stack_machine_core.sv
// top level of the byte stack machine core: sequencer around one byte memory
//
//  channel | valid / ready        | payload
//  input   | i_valid / o_ready    | i_operation, i_address, i_data
//  result  | o_valid / i_ready    | o_read_data .. o_interrupts_off
//  config  | i_cfg_valid / o_cfg_ready | i_cfg_data (machine size)
//
// one item at a time; every memory byte read goes through the single port
// byte memory (address state, then registered data), a write through S_WR.
// pointer ops read w pointer bytes off the stack; roll and insert read, then
// write, each byte walked (up to 257 bytes).
// reset is synchronous, active low; memory content is not cleared.
// the result register holds until taken; no new request is taken meanwhile.
`default_nettype none
module byte_stack_machine_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_operation,
    input  wire  [15:0] i_address,
    input  wire  [7:0]  i_data,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [7:0]  o_read_data,
    output logic [63:0] o_instr_pointer,
    output logic [63:0] o_stack_pointer,
    output logic [63:0] o_interrupt_vector,
    output logic        o_halted,
    output logic        o_interrupts_off,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_data
);
    // micro step codes inside an instruction
    localparam logic [4:0] M_FETCH = 5'd0;
    localparam logic [4:0] M_OPC   = 5'd1;
    localparam logic [4:0] M_A     = 5'd2;
    localparam logic [4:0] M_B     = 5'd3;
    localparam logic [4:0] M_C     = 5'd4;
    localparam logic [4:0] M_D     = 5'd5;
    localparam logic [4:0] M_POP   = 5'd6;
    localparam logic [4:0] M_POPD  = 5'd7;
    localparam logic [4:0] M_LOOP  = 5'd8;
    localparam logic [4:0] M_LOOPW = 5'd9;
    localparam logic [4:0] M_CW    = 5'd10;
    localparam logic [4:0] M_DONE  = 5'd11;
    localparam logic [4:0] M_BOOT  = 5'd12;
    localparam logic [4:0] M_READ  = 5'd13;
    localparam logic [4:0] M_E     = 5'd14;

    logic [3:0]  r_state, n_state;
    logic [4:0]  r_step, n_step;
    logic [1:0]  r_size;
    logic [63:0] r_ip, n_ip, r_sp, n_sp, r_irp, n_irp;
    logic        r_brk, n_brk, r_dis, n_dis;
    logic [7:0]  r_rd, n_rd;
    logic [63:0] r_addr, n_addr;
    logic [7:0]  r_wdata, n_wdata;
    logic [7:0]  r_op, n_op;
    logic [7:0]  r_off, n_off;
    logic [7:0]  r_x, n_x, r_y, n_y, r_t, n_t;
    logic [63:0] r_acc, n_acc;
    logic [8:0]  r_cnt, n_cnt;
    logic [63:0] r_next, n_next;
    logic        r_alt, n_alt;
    logic [7:0]  mem_rdata;
    logic        mem_we;
    logic [3:0]  wbytes;
    logic [8:0]  s;

    assign wbytes = 4'd1 << r_size;

    // byte memory
    assign mem_we = (r_state == bsm_pkg::S_WR);
    bsm_ram #(.Width(8), .Depth(bsm_pkg::MemBytes)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (r_addr[bsm_pkg::MemAw-1:0]),
        .i_wdata(r_wdata),
        .o_rdata(mem_rdata)
    );

    assign o_ready     = (r_state == bsm_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == bsm_pkg::S_IDLE);
    assign o_valid     = (r_state == bsm_pkg::S_OUT);
    assign o_read_data = r_rd;
    assign o_instr_pointer    = r_ip;
    assign o_stack_pointer    = r_sp;
    assign o_interrupt_vector = r_irp;
    assign o_halted           = r_brk;
    assign o_interrupts_off   = r_dis;

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsm_pkg::S_IDLE;
            r_step  <= M_FETCH;
            r_size  <= 2'd1;
            r_ip    <= '0;
            r_sp    <= '0;
            r_irp   <= '0;
            r_brk   <= 1'b0;
            r_dis   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ip    <= n_ip;
            r_sp    <= n_sp;
            r_irp   <= n_irp;
            r_brk   <= n_brk;
            r_dis   <= n_dis;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
        end
        r_rd <= n_rd; r_addr <= n_addr; r_wdata <= n_wdata; r_op <= n_op;
        r_off <= n_off; r_x <= n_x; r_y <= n_y; r_t <= n_t; r_acc <= n_acc;
        r_cnt <= n_cnt; r_next <= n_next; r_alt <= n_alt;
    end

    // sequencer: each step either issues a read (S_RD, data back in S_WT)
    // or a write (S_WR), then continues with r_step
    always_comb begin
        n_state = r_state; n_step = r_step;
        n_ip = r_ip; n_sp = r_sp; n_irp = r_irp; n_brk = r_brk; n_dis = r_dis;
        n_rd = r_rd; n_addr = r_addr; n_wdata = r_wdata; n_op = r_op;
        n_off = r_off; n_x = r_x; n_y = r_y; n_t = r_t; n_acc = r_acc;
        n_cnt = r_cnt; n_next = r_next; n_alt = r_alt;
        s = '0;
        case (r_state)
            bsm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_rd = 8'd0;
                    n_addr = {48'd0, i_address};
                    case (i_operation)
                        bsm_pkg::OP_LOAD: begin
                            n_wdata = i_data;
                            n_step = M_DONE;
                            n_state = bsm_pkg::S_WR;
                        end
                        bsm_pkg::OP_READ: begin
                            n_step = M_READ;
                            n_state = bsm_pkg::S_RD;
                        end
                        bsm_pkg::OP_BOOT: begin
                            n_addr = '0; n_acc = '0; n_cnt = '0; n_alt = 1'b0;
                            n_step = M_BOOT;
                            n_state = bsm_pkg::S_RD;
                        end
                        default: begin
                            n_addr = r_ip;
                            n_step = M_OPC;
                            n_state = bsm_pkg::S_RD;
                        end
                    endcase
                end
            end
            bsm_pkg::S_RD: n_state = bsm_pkg::S_WT;
            bsm_pkg::S_OUT: if (i_ready) n_state = bsm_pkg::S_IDLE;
            bsm_pkg::S_WR, bsm_pkg::S_WT: begin
                n_state = bsm_pkg::S_RD;  // default: another read
                case (r_step)
                    M_DONE: n_state = bsm_pkg::S_OUT;
                    M_READ: begin
                        n_rd = mem_rdata;
                        n_state = bsm_pkg::S_OUT;
                    end
                    // boot: w bytes of sp at 0, then w bytes of ip at 2w
                    M_BOOT: begin
                        n_acc = {r_acc[55:0], mem_rdata};
                        n_cnt = r_cnt + 9'd1;
                        n_addr = r_addr + 64'd1;
                        if (r_cnt[3:0] == wbytes - 4'd1) begin
                            n_cnt = '0;
                            if (!r_alt) begin
                                n_sp = n_acc; n_alt = 1'b1;
                                n_acc = '0;
                                n_addr = {59'd0, wbytes, 1'b0};
                            end else begin
                                n_ip = n_acc; n_irp = '0;
                                n_brk = 1'b0; n_dis = 1'b0;
                                n_state = bsm_pkg::S_OUT;
                            end
                        end
                    end
                    // opcode in; default next ip
                    M_OPC: begin
                        n_op = mem_rdata;
                        n_next = bsm_pkg::wmask(r_size, r_ip + 64'd1);
                        n_addr = bsm_pkg::wmask(r_size, r_sp - 64'd1);
                        n_step = M_A;
                        n_acc = '0; n_cnt = '0;
                        case (mem_rdata)
                            bsm_pkg::I_BRK: begin
                                n_brk = 1'b1; n_ip = n_next;
                                n_state = bsm_pkg::S_OUT;
                            end
                            bsm_pkg::I_DROP: begin
                                n_sp = n_addr; n_ip = n_next;
                                n_state = bsm_pkg::S_OUT;
                            end
                            bsm_pkg::I_PUSH: n_addr = n_next;
                            bsm_pkg::I_LD, bsm_pkg::I_ST, bsm_pkg::I_JMP,
                            bsm_pkg::I_BR, bsm_pkg::I_CALL, bsm_pkg::I_SIV: begin
                                n_addr = bsm_pkg::wmask(r_size,
                                    r_sp - {60'd0, wbytes});
                                n_step = M_POP;
                            end
                            bsm_pkg::I_SWAP, bsm_pkg::I_PICK, bsm_pkg::I_PAST,
                            bsm_pkg::I_ROLL, bsm_pkg::I_INS, bsm_pkg::I_SEI,
                            bsm_pkg::I_ADD, bsm_pkg::I_SUB, bsm_pkg::I_ADC,
                            bsm_pkg::I_SBB, bsm_pkg::I_AND, bsm_pkg::I_OR,
                            bsm_pkg::I_XOR, bsm_pkg::I_SHL, bsm_pkg::I_SHR,
                            bsm_pkg::I_EQ, bsm_pkg::I_NE: ;
                            default: begin
                                n_ip = n_next;
                                n_state = bsm_pkg::S_OUT;
                            end
                        endcase
                    end
                    // first stack byte (or push literal)
                    M_A: begin
                        n_t = mem_rdata;  // srd(1)
                        n_off = mem_rdata;
                        n_step = M_B;
                        n_addr = bsm_pkg::wmask(r_size, r_sp - 64'd2);
                        case (r_op)
                            bsm_pkg::I_PUSH: begin
                                n_wdata = mem_rdata;
                                n_addr = bsm_pkg::wmask(r_size, r_sp);
                                n_sp = bsm_pkg::wmask(r_size, r_sp + 64'd1);
                                n_next = bsm_pkg::wmask(r_size, r_ip + 64'd2);
                                n_step = M_E;
                                n_state = bsm_pkg::S_WR;
                            end
                            bsm_pkg::I_SEI: begin
                                n_dis = (mem_rdata != 8'd0);
                                n_sp = bsm_pkg::wmask(r_size, r_sp - 64'd1);
                                n_ip = r_next;
                                n_state = bsm_pkg::S_OUT;
                            end
                            bsm_pkg::I_SHL, bsm_pkg::I_SHR: begin
                                n_wdata = (r_op == bsm_pkg::I_SHL) ?
                                    {mem_rdata[6:0], 1'b0} : {1'b0, mem_rdata[7:1]};
                                n_addr = r_addr;
                                n_step = M_E;
                                n_state = bsm_pkg::S_WR;
                            end
                            bsm_pkg::I_PICK: n_addr = bsm_pkg::wmask(r_size,
                                r_sp - 64'd2 - {56'd0, mem_rdata});
                            bsm_pkg::I_ROLL: n_addr = bsm_pkg::wmask(r_size,
                                r_sp - 64'd2 - {56'd0, mem_rdata});
                            default: ;
                        endcase
                    end
                    // second read
                    M_B: begin
                        n_x = mem_rdata;
                        n_step = M_C;
                        case (r_op)
                            bsm_pkg::I_PICK: begin
                                n_wdata = mem_rdata;
                                n_addr = bsm_pkg::wmask(r_size, r_sp - 64'd1);
                                n_step = M_E;
                                n_state = bsm_pkg::S_WR;
                            end
                            bsm_pkg::I_PAST: begin
                                n_wdata = mem_rdata;
                                n_addr = bsm_pkg::wmask(r_size,
                                    r_sp - 64'd3 - {56'd0, r_off});
                                n_sp = bsm_pkg::wmask(r_size, r_sp - 64'd2);
                                n_step = M_E;
                                n_state = bsm_pkg::S_WR;
                            end
                            bsm_pkg::I_SWAP: n_addr = bsm_pkg::wmask(r_size,
                                r_sp - 64'd2 - {56'd0, r_off});
                            bsm_pkg::I_ROLL: begin
                                // x = srd(2+off); walk i = 0..off
                                n_cnt = '0;
                                n_addr = bsm_pkg::wmask(r_size, r_sp - 64'd2);
                                n_step = M_LOOP;
                            end
                            bsm_pkg::I_INS: begin
                                n_cnt = '0;
                                n_addr = bsm_pkg::wmask(r_size,
                                    r_sp - 64'd3 - {56'd0, r_off});
                                n_step = M_LOOP;
                            end
                            bsm_pkg::I_ADC, bsm_pkg::I_SBB:
                                n_addr = bsm_pkg::wmask(r_size, r_sp - 64'd3);
                            default: begin
                                // two operand ops: x=srd(2), t=srd(1)
                                n_addr = r_addr;
                                n_sp = bsm_pkg::wmask(r_size, r_sp - 64'd1);
                                n_step = M_E;
                                n_state = bsm_pkg::S_WR;
                                case (r_op)
                                    bsm_pkg::I_ADD: n_wdata = mem_rdata + r_t;
                                    bsm_pkg::I_SUB: n_wdata = mem_rdata - r_t;
                                    bsm_pkg::I_AND: n_wdata = mem_rdata & r_t;
                                    bsm_pkg::I_OR:  n_wdata = mem_rdata | r_t;
                                    bsm_pkg::I_XOR: n_wdata = mem_rdata ^ r_t;
                                    bsm_pkg::I_EQ:
                                        n_wdata = {7'd0, mem_rdata == r_t};
                                    default:
                                        n_wdata = {7'd0, mem_rdata != r_t};
                                endcase
                            end
                        endcase
                    end
                    // third read: swap partner or carry operand
                    M_C: begin
                        n_y = mem_rdata;
                        n_state = bsm_pkg::S_WR;
                        n_step = M_D;
                        if (r_op == bsm_pkg::I_SWAP) begin
                            n_wdata = mem_rdata;
                            n_addr = bsm_pkg::wmask(r_size, r_sp - 64'd2);
                        end else begin
                            if (r_op == bsm_pkg::I_ADC)
                                s = {1'b0, mem_rdata} + {1'b0, r_x} + {8'd0, r_t != 8'd0};
                            else
                                s = {1'b0, mem_rdata} - {1'b0, r_x} - {8'd0, r_t != 8'd0};
                            n_wdata = s[7:0];
                            n_acc = {55'd0, s};
                        end
                    end
                    // second write of swap / carry
                    M_D: begin
                        n_state = bsm_pkg::S_WR;
                        n_step = M_E;
                        n_sp = bsm_pkg::wmask(r_size, r_sp - 64'd1);
                        if (r_op == bsm_pkg::I_SWAP) begin
                            n_wdata = r_x;
                            n_addr = bsm_pkg::wmask(r_size,
                                r_sp - 64'd2 - {56'd0, r_off});
                        end else begin
                            n_wdata = {7'd0, r_acc[8]};
                            n_addr = bsm_pkg::wmask(r_size, r_sp - 64'd2);
                        end
                    end
                    // rotate walk: read, then write carried byte
                    M_LOOP: begin
                        n_t = mem_rdata;
                        n_wdata = r_x;
                        n_x = mem_rdata;
                        n_step = M_LOOPW;
                        n_state = bsm_pkg::S_WR;
                    end
                    M_LOOPW: begin
                        n_cnt = r_cnt + 9'd1;
                        if (r_op == bsm_pkg::I_ROLL) begin
                            n_addr = bsm_pkg::wmask(r_size, r_addr - 64'd1);
                            if (r_cnt == {1'b0, r_off}) begin
                                n_sp = bsm_pkg::wmask(r_size, r_sp - 64'd1);
                                n_ip = r_next;
                                n_state = bsm_pkg::S_OUT;
                            end else begin
                                n_step = M_LOOP;
                            end
                        end else begin
                            n_addr = bsm_pkg::wmask(r_size, r_addr + 64'd1);
                            if (r_cnt == {1'b0, r_off} + 9'd1) begin
                                n_sp = bsm_pkg::wmask(r_size, r_sp - 64'd1);
                                n_ip = r_next;
                                n_state = bsm_pkg::S_OUT;
                            end else begin
                                n_step = M_LOOP;
                            end
                        end
                    end
                    // gather a big-endian pointer from sp-w .. sp-1
                    M_POP: begin
                        n_acc = {r_acc[55:0], mem_rdata};
                        n_cnt = r_cnt + 9'd1;
                        n_addr = bsm_pkg::wmask(r_size, r_addr + 64'd1);
                        if (r_cnt[3:0] == wbytes - 4'd1) begin
                            n_cnt = '0;
                            n_step = M_POPD;
                            n_sp = bsm_pkg::wmask(r_size, r_sp - {60'd0, wbytes});
                            case (r_op)
                                bsm_pkg::I_LD: n_addr = n_acc;
                                bsm_pkg::I_ST: n_addr =
                                    bsm_pkg::wmask(r_size, n_sp - 64'd1);
                                bsm_pkg::I_BR: n_addr =
                                    bsm_pkg::wmask(r_size, n_sp - 64'd1);
                                bsm_pkg::I_JMP: begin
                                    n_ip = n_acc;
                                    n_state = bsm_pkg::S_OUT;
                                end
                                bsm_pkg::I_SIV: begin
                                    n_irp = n_acc; n_ip = r_next;
                                    n_state = bsm_pkg::S_OUT;
                                end
                                default: begin
                                    // call: sp unchanged, write return lsb first
                                    n_sp = r_sp;
                                    n_addr = bsm_pkg::wmask(r_size, r_sp - 64'd1);
                                    n_wdata = r_next[7:0];
                                    n_t = 8'd0;
                                    n_step = M_CW;
                                    n_state = bsm_pkg::S_WR;
                                end
                            endcase
                        end
                    end
                    M_POPD: begin
                        case (r_op)
                            bsm_pkg::I_LD: begin
                                n_wdata = mem_rdata;
                                n_addr = r_sp;
                                n_sp = bsm_pkg::wmask(r_size, r_sp + 64'd1);
                                n_step = M_E;
                                n_state = bsm_pkg::S_WR;
                            end
                            bsm_pkg::I_ST: begin
                                n_wdata = mem_rdata;
                                n_addr = r_acc;
                                n_sp = bsm_pkg::wmask(r_size, r_sp - 64'd1);
                                n_step = M_E;
                                n_state = bsm_pkg::S_WR;
                            end
                            default: begin
                                n_ip = (mem_rdata != 8'd0) ? r_acc : r_next;
                                n_state = bsm_pkg::S_OUT;
                            end
                        endcase
                    end
                    // call return address bytes
                    M_CW: begin
                        n_t = r_t + 8'd1;
                        if (r_t[3:0] == wbytes - 4'd1) begin
                            n_ip = r_acc;
                            n_state = bsm_pkg::S_OUT;
                        end else begin
                            n_addr = bsm_pkg::wmask(r_size, r_addr - 64'd1);
                            n_wdata = 8'(r_next >> {r_t[2:0] + 3'd1, 3'b000});
                            n_state = bsm_pkg::S_WR;
                        end
                    end
                    // final write done
                    default: begin
                        n_ip = r_next;
                        n_state = bsm_pkg::S_OUT;
                    end
                endcase
            end
            default: n_state = bsm_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### sim/tb.sv
// testbench for the byte stack machine core: memory image load, directed program, random programs
`default_nettype none
module tb;
    import bsm_pkg::*;

    localparam logic [7:0] NOP_OP     = 8'h10;
    localparam int         STALL_MAX  = 5000;
    localparam int         HOLD_LEN   = 400;
    localparam int         RAND_ITEMS = 1250;

    typedef struct packed {
        logic [7:0]  rd;
        logic [63:0] ip;
        logic [63:0] sp;
        logic [63:0] irp;
        logic        halt;
        logic        ioff;
    } state_out_t;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        bit          has_rd;
        logic [7:0]  rd;
        bit          has_ptr;
        logic [63:0] ip;
        logic [63:0] sp;
    } row_t;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready;
    logic [1:0]  i_operation;
    logic [15:0] i_address;
    logic [7:0]  i_data;
    logic        o_valid, i_ready;
    logic [7:0]  o_read_data;
    logic [63:0] o_instr_pointer, o_stack_pointer, o_interrupt_vector;
    logic        o_halted, o_interrupts_off;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_data;

    byte_stack_machine_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_address(i_address), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_read_data(o_read_data), .o_instr_pointer(o_instr_pointer),
        .o_stack_pointer(o_stack_pointer), .o_interrupt_vector(o_interrupt_vector),
        .o_halted(o_halted), .o_interrupts_off(o_interrupts_off),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // machine state as the core should hold it
    logic [7:0]  mem_img [0:65535];
    logic [63:0] cpu_ip, cpu_sp, cpu_irp;
    logic        cpu_brk, cpu_ioff;
    logic [1:0]  cpu_size;

    state_out_t  pending_states[$];
    int          errors      = 0;
    int          items_sent  = 0;
    int          results_got = 0;
    int          execs_run   = 0;
    int          snd_idle    = 0;
    int          rcv_stall   = 0;
    bit          hold_req    = 0;
    int          hold_left   = 0;
    int          quiet_cycles = 0;

    // clock
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // pointer masking at the active address width
    function automatic logic [63:0] amask(input logic [63:0] v);
        case (cpu_size)
            2'd0:    return v & 64'hff;
            2'd1:    return v & 64'hffff;
            2'd2:    return v & 64'hffff_ffff;
            default: return v;
        endcase
    endfunction

    function automatic logic [7:0] mem_rd(input logic [63:0] a);
        return mem_img[a[15:0]];
    endfunction

    function automatic void mem_wr(input logic [63:0] a, input logic [7:0] v);
        mem_img[a[15:0]] = v;
    endfunction

    function automatic logic [63:0] stk_addr(input logic [63:0] k);
        return amask(cpu_sp - k);
    endfunction

    function automatic logic [7:0] stk_rd(input logic [63:0] k);
        return mem_rd(stk_addr(k));
    endfunction

    // big-endian address off the stack top, popped
    function automatic logic [63:0] pop_addr(input int w);
        logic [63:0] a;
        a = 0;
        for (int i = 0; i < w; i++)
            a = (a << 8) | mem_rd(amask(cpu_sp - w + i));
        cpu_sp = amask(cpu_sp - w);
        return a;
    endfunction

    function automatic void bin_write(input logic [7:0] v);
        mem_wr(stk_addr(2), v);
        cpu_sp = stk_addr(1);
    endfunction

    // one instruction at ip
    function automatic void run_instr();
        int          w;
        logic [7:0]  opc, x, y, t;
        logic [63:0] nxt, off, a, r;
        logic [31:0] s;
        w   = 1 << cpu_size;
        opc = mem_rd(cpu_ip);
        nxt = amask(cpu_ip + 1);
        case (opc)
            I_BRK: cpu_brk = 1;
            I_PUSH: begin
                mem_wr(stk_addr(0), mem_rd(amask(cpu_ip + 1)));
                cpu_sp = amask(cpu_sp + 1);
                nxt = amask(cpu_ip + 2);
            end
            I_DROP: cpu_sp = stk_addr(1);
            I_SWAP: begin
                off = stk_rd(1);
                x = stk_rd(2);
                y = stk_rd(2 + off);
                mem_wr(stk_addr(2), y);
                mem_wr(stk_addr(2 + off), x);
                cpu_sp = stk_addr(1);
            end
            I_PICK: begin
                off = stk_rd(1);
                mem_wr(stk_addr(1), stk_rd(2 + off));
            end
            I_PAST: begin
                off = stk_rd(1);
                mem_wr(stk_addr(3 + off), stk_rd(2));
                cpu_sp = stk_addr(2);
            end
            I_ROLL: begin
                off = stk_rd(1);
                x = stk_rd(2 + off);
                for (int i = 0; i <= off; i++) begin
                    t = stk_rd(2 + i);
                    mem_wr(stk_addr(2 + i), x);
                    x = t;
                end
                cpu_sp = stk_addr(1);
            end
            I_INS: begin
                off = stk_rd(1);
                x = stk_rd(2);
                for (int i = 0; i < off + 2; i++) begin
                    a = amask(cpu_sp - 3 - off + i);
                    t = mem_rd(a);
                    mem_wr(a, x);
                    x = t;
                end
                cpu_sp = stk_addr(1);
            end
            I_LD: begin
                a = pop_addr(w);
                mem_wr(cpu_sp, mem_rd(a));
                cpu_sp = amask(cpu_sp + 1);
            end
            I_ST: begin
                a = pop_addr(w);
                mem_wr(a, stk_rd(1));
                cpu_sp = stk_addr(1);
            end
            I_JMP: nxt = pop_addr(w);
            I_BR: begin
                a = pop_addr(w);
                if (stk_rd(1) != 0) nxt = a;
            end
            I_CALL: begin
                // whole target read before the return address overwrites it
                a = 0;
                for (int i = 0; i < w; i++)
                    a = (a << 8) | mem_rd(amask(cpu_sp - w + i));
                r = nxt;
                for (int i = 0; i < w; i++) begin
                    mem_wr(stk_addr(1 + i), r[7:0]);
                    r = r >> 8;
                end
                nxt = a;
            end
            I_SEI: begin
                cpu_ioff = stk_rd(1) != 0;
                cpu_sp = stk_addr(1);
            end
            I_SIV: cpu_irp = pop_addr(w);
            I_ADD: bin_write(stk_rd(2) + stk_rd(1));
            I_SUB: bin_write(stk_rd(2) - stk_rd(1));
            I_ADC, I_SBB: begin
                t = (stk_rd(1) != 0) ? 8'd1 : 8'd0;
                y = stk_rd(2);
                x = stk_rd(3);
                if (opc == I_ADC) s = 32'(x) + 32'(y) + 32'(t);
                else              s = 32'(x) - 32'(y) - 32'(t);
                mem_wr(stk_addr(3), s[7:0]);
                mem_wr(stk_addr(2), {7'd0, s[8]});
                cpu_sp = stk_addr(1);
            end
            I_AND: bin_write(stk_rd(1) & stk_rd(2));
            I_OR:  bin_write(stk_rd(1) | stk_rd(2));
            I_XOR: bin_write(stk_rd(1) ^ stk_rd(2));
            I_SHL: mem_wr(stk_addr(1), {stk_rd(1)[6:0], 1'b0});
            I_SHR: mem_wr(stk_addr(1), {1'b0, stk_rd(1)[7:1]});
            I_EQ:  bin_write((stk_rd(1) == stk_rd(2)) ? 8'd1 : 8'd0);
            I_NE:  bin_write((stk_rd(1) != stk_rd(2)) ? 8'd1 : 8'd0);
            default: ;
        endcase
        cpu_ip = nxt;
    endfunction

    // apply one request to the machine state and return what the core reports
    function automatic state_out_t apply_request(input logic [1:0] op, input logic [15:0] addr,
                                                 input logic [7:0] data);
        state_out_t  o;
        int          w;
        logic [63:0] s, p;
        o.rd = 0;
        case (op)
            OP_LOAD: mem_img[addr] = data;
            OP_READ: o.rd = mem_img[addr];
            OP_BOOT: begin
                w = 1 << cpu_size;
                s = 0;
                p = 0;
                for (int i = 0; i < w; i++) s = (s << 8) | mem_img[i];
                for (int i = 0; i < w; i++) p = (p << 8) | mem_img[2 * w + i];
                cpu_sp = s;
                cpu_ip = p;
                cpu_irp = 0;
                cpu_brk = 0;
                cpu_ioff = 0;
            end
            default: run_instr();
        endcase
        o.ip = cpu_ip;
        o.sp = cpu_sp;
        o.irp = cpu_irp;
        o.halt = cpu_brk;
        o.ioff = cpu_ioff;
        return o;
    endfunction

    // send one request, predict its result on acceptance
    task automatic send_request(input logic [1:0] op, input logic [15:0] addr,
                                input logic [7:0] data, output state_out_t predicted);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid     <= 1;
        i_operation <= op;
        i_address   <= addr;
        i_data      <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = apply_request(op, addr, data);
        pending_states.push_back(predicted);
        items_sent++;
        if (op == OP_EXEC) execs_run++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (pending_states.size() != 0) @(negedge i_clk);
    endtask

    // size register write, only with the core idle
    task automatic write_size(input logic [1:0] v);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cpu_size = v;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        state_out_t e;
        if (i_rst_n && o_valid && i_ready) begin
            results_got++;
            if (pending_states.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                e = pending_states.pop_front();
                if (o_read_data !== e.rd) begin
                    $error("read_data exp %h got %h", e.rd, o_read_data); errors++;
                end
                if (o_instr_pointer !== e.ip) begin
                    $error("instr_pointer exp %h got %h", e.ip, o_instr_pointer); errors++;
                end
                if (o_stack_pointer !== e.sp) begin
                    $error("stack_pointer exp %h got %h", e.sp, o_stack_pointer); errors++;
                end
                if (o_interrupt_vector !== e.irp) begin
                    $error("interrupt_vector exp %h got %h", e.irp, o_interrupt_vector);
                    errors++;
                end
                if (o_halted !== e.halt) begin
                    $error("halted exp %b got %b", e.halt, o_halted); errors++;
                end
                if (o_interrupts_off !== e.ioff) begin
                    $error("interrupts_off exp %b got %b", e.ioff, o_interrupts_off); errors++;
                end
            end
        end
    end

    // receiver stalls, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_stall);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // directed program with hand-computed values where obvious
    row_t rows [24] = '{
        '{OP_LOAD, 16'h0000, 8'h01, 0, 0, 0, 0, 0},
        '{OP_LOAD, 16'h0001, 8'h00, 0, 0, 0, 0, 0},
        '{OP_LOAD, 16'h0004, 8'h02, 0, 0, 0, 0, 0},
        '{OP_LOAD, 16'h0005, 8'h00, 0, 0, 0, 0, 0},
        '{OP_BOOT, 16'h0000, 8'h00, 1, 8'h00, 1, 64'h200, 64'h100},
        '{OP_LOAD, 16'h0200, I_PUSH, 0, 0, 0, 0, 0},
        '{OP_LOAD, 16'h0201, 8'hff, 0, 0, 0, 0, 0},
        '{OP_EXEC, 16'h0000, 8'h00, 1, 8'h00, 1, 64'h202, 64'h101},
        '{OP_LOAD, 16'h0202, I_PUSH, 0, 0, 0, 0, 0},
        '{OP_LOAD, 16'h0203, 8'h01, 0, 0, 0, 0, 0},
        '{OP_EXEC, 16'h0000, 8'h00, 1, 8'h00, 1, 64'h204, 64'h102},
        '{OP_LOAD, 16'h0204, I_ADD, 0, 0, 0, 0, 0},
        '{OP_EXEC, 16'hffff, 8'hff, 1, 8'h00, 1, 64'h205, 64'h101},
        '{OP_READ, 16'h0100, 8'h00, 1, 8'h00, 1, 64'h205, 64'h101},
        '{OP_LOAD, 16'h0205, 8'hff, 0, 0, 0, 0, 0},
        '{OP_EXEC, 16'h0000, 8'h00, 1, 8'h00, 1, 64'h206, 64'h101},
        '{OP_LOAD, 16'h0206, I_BRK, 0, 0, 0, 0, 0},
        '{OP_EXEC, 16'h0000, 8'h00, 1, 8'h00, 1, 64'h207, 64'h101},
        '{OP_LOAD, 16'hffff, 8'hff, 0, 0, 0, 0, 0},
        '{OP_READ, 16'hffff, 8'h00, 1, 8'hff, 0, 0, 0},
        '{OP_LOAD, 16'hffff, 8'h00, 0, 0, 0, 0, 0},
        '{OP_READ, 16'hffff, 8'hff, 1, 8'h00, 0, 0, 0},
        '{OP_LOAD, 16'haaaa, 8'h55, 0, 0, 0, 0, 0},
        '{OP_READ, 16'haaaa, 8'haa, 1, 8'h55, 0, 0, 0}
    };

    logic [7:0] opcodes [28] = '{
        I_BRK, NOP_OP, I_PUSH, I_DROP, I_SWAP, I_PICK, I_PAST, I_ROLL, I_INS,
        I_LD, I_ST, I_JMP, I_BR, I_CALL, I_SEI, I_SIV, I_ADD, I_SUB, I_ADC,
        I_SBB, I_AND, I_OR, I_XOR, I_SHL, I_SHR, I_EQ, I_NE, 8'hff
    };
    logic [1:0] size_plan [8] = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1};

    // main sequence
    initial begin
        state_out_t  p;
        logic [7:0]  opc;
        logic [63:0] lit_addr;
        int          pick, phase, phase_end;
        i_rst_n = 0; i_valid = 0; i_operation = OP_LOAD; i_address = 0; i_data = 0;
        i_ready = 0; i_cfg_valid = 0; i_cfg_data = 0;
        cpu_ip = 0; cpu_sp = 0; cpu_irp = 0; cpu_brk = 0; cpu_ioff = 0; cpu_size = 2'd1;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        // whole memory image first, so no byte is ever read unwritten
        for (int a = 0; a < 65536; a++)
            send_request(OP_LOAD, 16'(a), 8'($urandom_range(255)), p);

        // directed program
        foreach (rows[r]) begin
            send_request(rows[r].op, rows[r].addr, rows[r].data, p);
            if (rows[r].has_rd && p.rd !== rows[r].rd) begin
                $error("row %0d read_data exp %h got %h", r, rows[r].rd, p.rd); errors++;
            end
            if (rows[r].has_ptr && (p.ip !== rows[r].ip || p.sp !== rows[r].sp)) begin
                $error("row %0d pointers exp %h/%h got %h/%h", r, rows[r].ip, rows[r].sp,
                       p.ip, p.sp);
                errors++;
            end
        end
        drain();

        // random programs over the size settings and idling modes
        for (phase = 0; phase < 8; phase++) begin
            write_size(size_plan[phase]);
            case (phase % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 49; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 49; end
                default: begin snd_idle = 6; rcv_stall = 6; end
            endcase
            if (phase == 1) hold_req = 1;
            phase_end = items_sent + RAND_ITEMS / 8;
            while (items_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    // opcode at ip, operands prepared, then execute
                    opc = opcodes[$urandom_range(27)];
                    if (opc == 8'hff) opc = 8'($urandom_range(255));
                    send_request(OP_LOAD, cpu_ip[15:0], opc, p);
                    if (opc == I_PUSH) begin
                        lit_addr = amask(cpu_ip + 1);
                        send_request(OP_LOAD, lit_addr[15:0], 8'($urandom_range(255)), p);
                    end else if (opc inside {I_SWAP, I_PICK, I_PAST, I_ROLL, I_INS}) begin
                        lit_addr = stk_addr(1);
                        send_request(OP_LOAD, lit_addr[15:0],
                                     ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                              : 8'($urandom_range(7)), p);
                    end
                    send_request(OP_EXEC, 16'($urandom_range(65535)),
                                 8'($urandom_range(255)), p);
                end else if (pick < 80) begin
                    send_request(OP_READ, 16'($urandom_range(65535)), 8'($urandom_range(255)), p);
                end else if (pick < 90) begin
                    send_request(OP_LOAD, 16'($urandom_range(65535)), 8'($urandom_range(255)), p);
                end else if (pick < 94) begin
                    send_request(OP_BOOT, 16'($urandom_range(65535)), 8'($urandom_range(255)), p);
                end else begin
                    send_request(OP_EXEC, 16'($urandom_range(65535)), 8'($urandom_range(255)), p);
                end
            end
        end
        write_size(2'd3);
        write_size(2'd1);

        // wait for the tail
        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests, %0d instructions executed, %0d results checked",
                 items_sent, execs_run, results_got);
        $display("all four address widths, four idling modes and one long result hold-off");
        if (errors == 0 && pending_states.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

### files.f
src/bsm_pkg.sv
src/bsm_ram.sv
src/byte_stack_machine_core.sv
sim/tb.sv
